### src/lru_byte_budget_cache_directory_top_macros.svh
// Assertion macros shared by the cache directory checker.
`ifndef LRU_BYTE_BUDGET_CACHE_DIRECTORY_TOP_MACROS_SVH
`define LRU_BYTE_BUDGET_CACHE_DIRECTORY_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define LBBCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbbcd: implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define LBBCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbbcd: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define LBBCD_ASSERT_NXT_ANY(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbbcd: reset-time check failed");

`endif

### src/lbbcd_pkg.sv
// Types, widths and constants of the cache directory.
`default_nettype none

package lbbcd_pkg;

    localparam int DEFAULT_ENTRIES = 64;

    localparam int LAYER_W  = 8;
    localparam int KIND_W   = 2;
    localparam int EXPERT_W = 8;
    localparam int SIZE_W   = 32;
    localparam int CAP_W    = 41;
    localparam int STAMP_W  = 64;
    localparam int CNT_W    = 32;
    localparam int EVICT_W  = 7;

    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(67108864);
    localparam logic [EVICT_W-1:0] EVICT_MAX = {EVICT_W{1'b1}};

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [LAYER_W-1:0]  layer;
        logic [KIND_W-1:0]   kind;
        logic [EXPERT_W-1:0] expert;
    } t_key;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_CHECK,
        S_LRU,
        S_EVICT,
        S_INSTALL,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

### src/lbbcd_ifs.sv
// Request and response channel interfaces of the cache directory.
`default_nettype none

interface lbbcd_req_if import lbbcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [LAYER_W-1:0]  layer_index;
    logic [KIND_W-1:0]   tensor_kind;
    logic [EXPERT_W-1:0] expert_id;
    logic [SIZE_W-1:0]   size_bytes;

    modport source (
        output valid, op, layer_index, tensor_kind, expert_id, size_bytes,
        input  ready
    );
    modport sink (
        input  valid, op, layer_index, tensor_kind, expert_id, size_bytes,
        output ready
    );
endinterface

interface lbbcd_rsp_if import lbbcd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [EVICT_W-1:0] evictions;
    logic [CAP_W-1:0]   bytes_in_use;
    logic [CNT_W-1:0]   total_hits;
    logic [CNT_W-1:0]   total_misses;

    modport source (
        output valid, hit, evictions, bytes_in_use, total_hits, total_misses,
        input  ready
    );
    modport sink (
        input  valid, hit, evictions, bytes_in_use, total_hits, total_misses,
        output ready
    );
endinterface

`default_nettype wire

### src/lru_byte_budget_cache_directory_top.sv
// Fully associative LRU cache directory with a byte budget.
// Each transaction on i_req is a lookup or an insert of a (layer, kind, expert) key and
// yields one transaction on o_rsp. Entries sit in a one-write, one-read memory that one
// compare unit walks slot by slot. A lookup or an insert of a present key scans every slot
// once for the key, and its response is loaded into the o_rsp register after that scan.
// An insert of an absent key adds the budget check and the install, and one
// least-recently-used scan per victim for every eviction forced by the budget and for
// the eviction forced by a full directory. The finished item holds in its last state for
// as long as the previous response still waits untaken in the o_rsp register.
// i_req.ready is high only between items, while a finished response may still wait in
// the o_rsp register. Valid bits reset at once, so no clearing pass follows reset.
// capacity_bytes may be written through i_cfg_wr_en and i_cfg_wr_data while the block
// is idle.
`default_nettype none

module lru_byte_budget_cache_directory_top import lbbcd_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CAP_W-1:0] i_cfg_wr_data,
    lbbcd_req_if.sink             i_req,
    lbbcd_rsp_if.source           o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // entry memories
    t_key               mem_key   [ENTRIES];
    logic [SIZE_W-1:0]  mem_size  [ENTRIES];
    logic [STAMP_W-1:0] mem_stamp [ENTRIES];

    t_key               r_rd_key;
    logic [SIZE_W-1:0]  r_rd_size;
    logic [STAMP_W-1:0] r_rd_stamp;

    logic               w_ent_we;
    logic               w_stamp_we;
    logic [IW-1:0]      w_waddr;
    logic [STAMP_W-1:0] w_stamp_wdata;

    t_state r_state, n_state;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]      r_vcnt, n_vcnt;
    logic [CAP_W-1:0]   r_used, n_used;
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic [CNT_W-1:0]   r_hits, n_hits;
    logic [CNT_W-1:0]   r_misses, n_misses;
    logic [CAP_W-1:0]   r_cap;

    // current item
    logic              r_op;
    t_key              r_key;
    logic [SIZE_W-1:0] r_size;

    // scan engine
    logic [IW-1:0] r_idx, n_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_chk, n_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_chk_last;
    logic          w_scanning;
    logic          w_scan_end;
    logic          w_rd_valid;

    // search results
    logic               r_found, n_found;
    logic [IW-1:0]      r_slot, n_slot;
    logic               r_free_ok, n_free_ok;
    logic [IW-1:0]      r_free, n_free;
    logic               r_vfound, n_vfound;
    logic [IW-1:0]      r_victim, n_victim;
    logic [STAMP_W-1:0] r_best, n_best;
    logic [SIZE_W-1:0]  r_vsize, n_vsize;
    logic               r_final, n_final;
    logic [EVICT_W-1:0] r_evict, n_evict;

    // response register
    logic               r_o_valid, n_o_valid;
    logic               r_o_hit;
    logic [EVICT_W-1:0] r_o_evict;
    logic [CAP_W-1:0]   r_o_used;
    logic [CNT_W-1:0]   r_o_hits;
    logic [CNT_W-1:0]   r_o_misses;

    logic w_accept;
    logic w_load;
    logic w_over;
    logic w_full;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_scanning = (r_state == S_FIND) || (r_state == S_LRU);
    assign w_scan_end = r_chk && r_chk_last;
    assign w_rd_valid = r_valid[r_chk_idx];
    assign w_load     = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);
    assign w_over     = ({1'b0, r_used} + (CAP_W + 1)'(r_size)) > {1'b0, r_cap};
    assign w_full     = (r_vcnt == CW'(ENTRIES));

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.hit          = r_o_hit;
    assign o_rsp.evictions    = r_o_evict;
    assign o_rsp.bytes_in_use = r_o_used;
    assign o_rsp.total_hits   = r_o_hits;
    assign o_rsp.total_misses = r_o_misses;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_accept) n_state = S_FIND;
            S_FIND:    if (w_scan_end) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_op == OP_INSERT && !r_found) n_state = S_CHECK;
                else                               n_state = S_FIN;
            end
            S_CHECK: begin
                if ((w_over && r_vcnt != '0) || w_full) n_state = S_LRU;
                else                                    n_state = S_INSTALL;
            end
            S_LRU:     if (w_scan_end) n_state = S_EVICT;
            S_EVICT:   n_state = r_final ? S_INSTALL : S_CHECK;
            S_INSTALL: n_state = S_FIN;
            S_FIN:     if (w_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and sequencer outputs
    always_comb begin
        n_valid       = r_valid;
        n_vcnt        = r_vcnt;
        n_used        = r_used;
        n_clock       = r_clock;
        n_hits        = r_hits;
        n_misses      = r_misses;
        n_idx         = r_idx;
        n_issue_done  = r_issue_done;
        n_chk         = w_scanning && !r_issue_done;
        n_found       = r_found;
        n_slot        = r_slot;
        n_free_ok     = r_free_ok;
        n_free        = r_free;
        n_vfound      = r_vfound;
        n_victim      = r_victim;
        n_best        = r_best;
        n_vsize       = r_vsize;
        n_final       = r_final;
        n_evict       = r_evict;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        w_ent_we      = 1'b0;
        w_stamp_we    = 1'b0;
        w_waddr       = r_free;
        w_stamp_wdata = r_clock + STAMP_W'(1);

        // issue one slot address per cycle while scanning
        if (w_scanning && !r_issue_done) begin
            if (r_idx == LAST_IDX) n_issue_done = 1'b1;
            else                   n_idx = r_idx + IW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_found      = 1'b0;
                    n_free_ok    = 1'b0;
                    n_evict      = '0;
                end
            end
            S_FIND: begin
                if (r_chk) begin
                    if (w_rd_valid && r_rd_key == r_key && !r_found) begin
                        n_found = 1'b1;
                        n_slot  = r_chk_idx;
                    end
                    if (!w_rd_valid && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_chk_idx;
                    end
                end
            end
            S_DECIDE: begin
                if (r_op == OP_LOOKUP) begin
                    if (r_found) begin
                        n_hits     = r_hits + CNT_W'(1);
                        n_clock    = r_clock + STAMP_W'(1);
                        w_stamp_we = 1'b1;
                        w_waddr    = r_slot;
                    end else begin
                        n_misses = r_misses + CNT_W'(1);
                    end
                end
            end
            S_CHECK: begin
                n_idx        = '0;
                n_issue_done = 1'b0;
                n_vfound     = 1'b0;
                n_final      = !(w_over && r_vcnt != '0);
            end
            S_LRU: begin
                // strict compare keeps the lowest slot on equal stamps
                if (r_chk && w_rd_valid && (!r_vfound || r_rd_stamp < r_best)) begin
                    n_vfound = 1'b1;
                    n_victim = r_chk_idx;
                    n_best   = r_rd_stamp;
                    n_vsize  = r_rd_size;
                end
            end
            S_EVICT: begin
                n_valid[r_victim] = 1'b0;
                n_vcnt = r_vcnt - CW'(1);
                n_used = r_used - CAP_W'(r_vsize);
                if (r_evict != EVICT_MAX) n_evict = r_evict + EVICT_W'(1);
                if (!r_free_ok || r_victim < r_free) begin
                    n_free_ok = 1'b1;
                    n_free    = r_victim;
                end
            end
            S_INSTALL: begin
                w_ent_we        = 1'b1;
                w_stamp_we      = 1'b1;
                n_valid[r_free] = 1'b1;
                n_vcnt          = r_vcnt + CW'(1);
                n_used          = r_used + CAP_W'(r_size);
                n_clock         = r_clock + STAMP_W'(1);
            end
            S_FIN: begin
                if (w_load) n_o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_vcnt    <= '0;
            r_used    <= '0;
            r_clock   <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_cap     <= CAP_RESET;
            r_chk     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_vcnt    <= n_vcnt;
            r_used    <= n_used;
            r_clock   <= n_clock;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_chk     <= n_chk;
            r_o_valid <= n_o_valid;
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_issue_done <= n_issue_done;
        r_chk_idx    <= r_idx;
        r_chk_last   <= (r_idx == LAST_IDX);
        r_found      <= n_found;
        r_slot       <= n_slot;
        r_free_ok    <= n_free_ok;
        r_free       <= n_free;
        r_vfound     <= n_vfound;
        r_victim     <= n_victim;
        r_best       <= n_best;
        r_vsize      <= n_vsize;
        r_final      <= n_final;
        r_evict      <= n_evict;
        if (w_accept) begin
            r_op         <= i_req.op;
            r_key.layer  <= i_req.layer_index;
            r_key.kind   <= i_req.tensor_kind;
            r_key.expert <= i_req.expert_id;
            r_size       <= i_req.size_bytes;
        end
        if (w_load) begin
            r_o_hit    <= r_found;
            r_o_evict  <= r_evict;
            r_o_used   <= r_used;
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
        end
    end

    // entry memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            mem_key[w_waddr]  <= r_key;
            mem_size[w_waddr] <= r_size;
        end
        if (w_stamp_we) mem_stamp[w_waddr] <= w_stamp_wdata;
        r_rd_key   <= mem_key[r_idx];
        r_rd_size  <= mem_size[r_idx];
        r_rd_stamp <= mem_stamp[r_idx];
    end

endmodule

`default_nettype wire

### src/lbbcd_checker.sv
// Port-level checks of the cache directory and their binding to the top level.
`default_nettype none

`include "lru_byte_budget_cache_directory_top_macros.svh"

module lbbcd_checker import lbbcd_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_out_hit,
    input wire logic [EVICT_W-1:0] i_out_evictions
);

    // response holds until taken
    `LBBCD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // one item at a time: busy right after a transaction is taken
    `LBBCD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a present key never evicts
    `LBBCD_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, i_out_valid && i_out_hit,
                      i_out_evictions == '0)
    // reset drops any pending response
    `LBBCD_ASSERT_NXT_ANY(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind lru_byte_budget_cache_directory_top lbbcd_checker u_lbbcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_hit       (o_rsp.hit),
    .i_out_evictions (o_rsp.evictions)
);

`default_nettype wire
